[design/assert_macros.svh]
// assertion macros shared by the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds whenever reset is released
`define CHK_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// same-cycle implication
`define CHK_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

[design/sm3c_pkg.sv]
// types, constants and helper functions of the sm3 compression core
package sm3c_pkg;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [31:0] T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};

	localparam logic [31:0] IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	localparam logic [3:0] WORD_LAST  = 4'd15;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [5:0] ROUND_SWAP = 6'd15;
	localparam logic [2:0] DIGEST_LAST = 3'd7;

	typedef struct packed {
		logic [31:0] message_word;
		logic        first_block;
		logic        final_block;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        last_word;
	} digest_word_t;

	typedef struct packed {
		logic       shift_in;
		logic       load_iv;
		logic       init_work;
		logic       round;
		logic       low_rounds;
		logic       t_swap;
		logic       fold;
		logic       emit_load;
		logic [2:0] emit_idx;
	} dp_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} << n;
		return dbl[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

[design/sm3c_ctrl.sv]
// sequencer: word loading, round count and digest emission
module sm3c_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  sm3c_pkg::msg_word_t  msg,
	output logic                 digest_valid,
	input  logic                 digest_stall,
	output sm3c_pkg::dp_cmd_t    cmd
);
	import sm3c_pkg::*;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FOLD  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [3:0] pos_q;
	logic [5:0] round_q;
	logic [2:0] emit_q;
	logic       final_q;
	logic       valid_q;
	logic       msg_acc;
	logic       out_free;

	assign msg_stall    = (state_q != ST_LOAD);
	assign msg_acc      = msg_valid && !msg_stall;
	assign out_free     = !valid_q || !digest_stall;
	assign digest_valid = valid_q;

	always_comb begin
		cmd            = '0;
		cmd.shift_in   = msg_acc;
		cmd.load_iv    = msg_acc && (pos_q == '0) && msg.first_block;
		cmd.init_work  = msg_acc && (pos_q == WORD_LAST);
		cmd.round      = (state_q == ST_ROUND);
		cmd.low_rounds = (round_q[5:4] == 2'b00);
		cmd.t_swap     = (round_q == ROUND_SWAP);
		cmd.fold       = (state_q == ST_FOLD);
		cmd.emit_load  = (state_q == ST_EMIT) && out_free;
		cmd.emit_idx   = emit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pos_q   <= '0;
			round_q <= '0;
			emit_q  <= '0;
			final_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.emit_load) begin
				valid_q <= 1'b1;
			end else if (!digest_stall) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (msg_acc) begin
						pos_q <= pos_q + 4'd1;
						if (pos_q == WORD_LAST) begin
							final_q <= msg.final_block;
							round_q <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == ROUND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					emit_q  <= '0;
					state_q <= final_q ? ST_EMIT : ST_LOAD;
				end
				ST_EMIT: begin
					if (out_free) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == DIGEST_LAST) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

[design/sm3c_datapath.sv]
// message schedule, round unit, chaining value and digest output register
module sm3c_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sm3c_pkg::msg_word_t    msg,
	input  sm3c_pkg::dp_cmd_t      cmd,
	output sm3c_pkg::digest_word_t digest
);
	import sm3c_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] cv_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] tj_q;
	digest_word_t out_q;

	logic [31:0] w_next, a12, ss1, ss2, ff, gg, tt1, tt2;

	always_comb begin
		w_next = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
			^ rotl(w_q[3], 5'd7) ^ w_q[10];
		a12 = rotl(a_q, 5'd12);
		ss1 = rotl(a12 + e_q + tj_q, 5'd7);
		ss2 = ss1 ^ a12;
		if (cmd.low_rounds) begin
			ff = a_q ^ b_q ^ c_q;
			gg = e_q ^ f_q ^ g_q;
		end else begin
			ff = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			gg = (e_q & f_q) | (~e_q & g_q);
		end
		tt1 = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + h_q + ss1 + w_q[0];
	end

	// block word shift line, W[j] sits at the head during round j
	always_ff @(posedge clk) begin
		if (cmd.shift_in || cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= cmd.shift_in ? msg.message_word : w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= IV;
		end else if (cmd.load_iv) begin
			cv_q <= IV;
		end else if (cmd.fold) begin
			cv_q[0] <= cv_q[0] ^ a_q;
			cv_q[1] <= cv_q[1] ^ b_q;
			cv_q[2] <= cv_q[2] ^ c_q;
			cv_q[3] <= cv_q[3] ^ d_q;
			cv_q[4] <= cv_q[4] ^ e_q;
			cv_q[5] <= cv_q[5] ^ f_q;
			cv_q[6] <= cv_q[6] ^ g_q;
			cv_q[7] <= cv_q[7] ^ h_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			a_q  <= cv_q[0];
			b_q  <= cv_q[1];
			c_q  <= cv_q[2];
			d_q  <= cv_q[3];
			e_q  <= cv_q[4];
			f_q  <= cv_q[5];
			g_q  <= cv_q[6];
			h_q  <= cv_q[7];
			tj_q <= T_LOW;
		end else if (cmd.round) begin
			d_q  <= c_q;
			c_q  <= rotl(b_q, 5'd9);
			b_q  <= a_q;
			a_q  <= tt1;
			h_q  <= g_q;
			g_q  <= rotl(f_q, 5'd19);
			f_q  <= e_q;
			e_q  <= perm0(tt2);
			tj_q <= cmd.t_swap ? T_HIGH_ROT16 : rotl(tj_q, 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_q.digest_word  <= cv_q[cmd.emit_idx];
			out_q.digest_index <= cmd.emit_idx;
			out_q.last_word    <= (cmd.emit_idx == DIGEST_LAST);
		end
	end

	assign digest = out_q;

endmodule

[design/sm3_compression.sv]
// sm3 compression core top level
//
// msg channel: one 32-bit word of a padded 512-bit block per transfer, most
// significant word of the block first. first_block on the first word of a
// block reloads the initial vector; final_block on the sixteenth word asks
// for the digest once that block is compressed.
// digest channel: eight words, index 0 (most significant) to 7, with
// last_word set on the eighth.
// Timing: the sixteen words of a block are taken one per cycle. The
// sixteenth word starts 64 rounds at one round per cycle in the round unit,
// followed by a fold state that folds the result into the chaining value.
// msg_stall is high for the rounds and the fold. On a final block the
// digest words follow at one per cycle while digest_stall is low, through
// the emit state and then the output register after the fold; msg_stall
// stays high until the eighth word has been loaded.
// A digest stall holds the output register and the emission sequence; words
// of the next block are taken while the last digest word still waits.
// Reset sets the chaining value to the initial vector, clears the word
// position and drops digest_valid.
module sm3_compression (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	output logic                   msg_stall,
	input  sm3c_pkg::msg_word_t    msg,
	output logic                   digest_valid,
	input  logic                   digest_stall,
	output sm3c_pkg::digest_word_t digest
);
	import sm3c_pkg::*;

	dp_cmd_t cmd;

	sm3c_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.cmd          (cmd)
	);

	sm3c_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cmd    (cmd),
		.digest (digest)
	);

endmodule

[design/sm3c_checker.sv]
// port checker of the sm3 compression core, bound to the top level
`include "assert_macros.svh"

module sm3c_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   msg_valid,
	input logic                   msg_stall,
	input sm3c_pkg::msg_word_t    msg,
	input logic                   digest_valid,
	input logic                   digest_stall,
	input sm3c_pkg::digest_word_t digest
);
	import sm3c_pkg::*;

	logic [2:0] exp_idx_q;
	logic       msg_seen;

	assign msg_seen = msg_valid && msg.first_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (digest_valid && !digest_stall) begin
			exp_idx_q <= digest.last_word ? 3'd0 : exp_idx_q + 3'd1;
		end
	end

	`CHK_NEXT(a_digest_hold, clk, arst_n, digest_valid && digest_stall, digest_valid && $stable(digest))
	`CHK_IMPLIES(a_last_flag, clk, arst_n, digest_valid, digest.last_word == (digest.digest_index == DIGEST_LAST))
	`CHK_IMPLIES(a_index_order, clk, arst_n, digest_valid, digest.digest_index == exp_idx_q)
	`CHK_IMPLIES(a_no_msg_mid_digest, clk, arst_n, (exp_idx_q != 3'd0) && (exp_idx_q != DIGEST_LAST) && (msg_seen || msg_valid), msg_stall)

endmodule

bind sm3_compression sm3c_checker u_checker (.*);

[test/sm3_checker.sv]
// digest checker for the sm3 compression core: predicts digest words from the message words it sees
module sm3_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	input  logic                   msg_stall,
	input  sm3c_pkg::msg_word_t    msg,
	input  logic                   digest_valid,
	input  logic                   digest_stall,
	input  sm3c_pkg::digest_word_t digest,
	output int                     fail_count,
	output int                     words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import sm3c_pkg::*;

	localparam logic [31:0] ROUND_CONST_EARLY = 32'h79CC4519;
	localparam logic [31:0] ROUND_CONST_LATE  = 32'h7A879D8A;
	localparam logic [31:0] START_VALUE [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	logic [31:0]  chain [8];
	logic [31:0]  block_buf [16];
	logic [3:0]   fill_pos;
	digest_word_t digest_due [$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
		int unsigned k;
		k = n % 32;
		if (k == 0)
			return x;
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic logic [31:0] mix0(input logic [31:0] x);
		return x ^ rol(x, 9) ^ rol(x, 17);
	endfunction

	function automatic logic [31:0] mix1(input logic [31:0] x);
		return x ^ rol(x, 15) ^ rol(x, 23);
	endfunction

	// expand the buffered block and fold 64 rounds into the chaining value
	function automatic void hash_block();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = block_buf[j];
		for (int j = 16; j < 68; j++)
			w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int j = 0; j < 64; j++) begin
			tj  = (j < 16) ? ROUND_CONST_EARLY : ROUND_CONST_LATE;
			a12 = rol(a, 12);
			ss1 = rol(a12 + e + rol(tj, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + h + ss1 + w[j];
			d = c;
			c = rol(b, 9);
			b = a;
			a = tt1;
			h = g;
			g = rol(f, 19);
			f = e;
			e = mix0(tt2);
		end
		chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
		chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_word_t want;
		if (!arst_n) begin
			chain = START_VALUE;
			fill_pos = '0;
			digest_due.delete();
			words_due <= 0;
			fail_count <= 0;
		end else begin
			if (msg_valid && !msg_stall) begin
				if (fill_pos == 4'd0 && msg.first_block)
					chain = START_VALUE;
				block_buf[fill_pos] = msg.message_word;
				if (fill_pos == 4'd15) begin
					hash_block();
					if (msg.final_block)
						for (int k = 0; k < 8; k++)
							digest_due.push_back('{chain[k], 3'(k), k == 7});
				end
				fill_pos = fill_pos + 4'd1;
			end
			if (digest_valid && !digest_stall) begin
				if (digest_due.size() == 0) begin
					$display("%0t: unexpected digest word %h index %0d last %b",
						$time, digest.digest_word, digest.digest_index, digest.last_word);
					fail_count <= fail_count + 1;
				end else begin
					want = digest_due.pop_front();
					if (want.digest_word !== digest.digest_word
							|| want.digest_index !== digest.digest_index
							|| want.last_word !== digest.last_word) begin
						$display("%0t: digest word expected %h/%0d/%b, got %h/%0d/%b", $time,
							want.digest_word, want.digest_index, want.last_word,
							digest.digest_word, digest.digest_index, digest.last_word);
						fail_count <= fail_count + 1;
					end
				end
			end
			words_due <= digest_due.size();
		end
	end

endmodule

[test/testbench.sv]
// stimulus and verdict for the sm3 compression core, with the digest checker beside it
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_TARGET = 450;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   msg_valid;
	logic                   msg_stall;
	sm3c_pkg::msg_word_t    msg;
	logic                   digest_valid;
	logic                   digest_stall;
	sm3c_pkg::digest_word_t digest;
	int                     fail_count;
	int                     words_due;
	int                     words_sent;
	int                     idle_cycles;

	sm3_compression u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	sm3_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest),
		.fail_count   (fail_count),
		.words_due    (words_due)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		digest_stall = 1'b0;
		words_sent = 0;
		idle_cycles = 0;
	end

	always #10 clk = ~clk;

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// offer one word and hold it until taken, then maybe idle
	task automatic offer_word(input logic [31:0] data, input logic first, input logic last);
		int gap;
		msg_valid <= 1'b1;
		msg <= '{data, first, last};
		do @(posedge clk); while (msg_stall);
		words_sent++;
		if (!(words_sent >= 200 && words_sent < 300) && $urandom_range(99) < 5) begin
			gap = $urandom_range(6, 1);
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mostly well-formed messages, the rest with flags scattered at random
	task automatic send_message(input int blocks);
		bit scrambled;
		scrambled = $urandom_range(99) < 20;
		for (int b = 0; b < blocks; b++)
			for (int i = 0; i < 16; i++)
				if (scrambled)
					offer_word(pick_word(), $urandom_range(3) == 0, $urandom_range(3) == 0);
				else
					offer_word(pick_word(), b == 0 && i == 0, b == blocks - 1 && i == 15);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// no start flag after reset, stray flags mid-block, extreme words
		for (int i = 0; i < 16; i++)
			offer_word(i % 2 ? 32'hFFFF_FFFF : 32'h0000_0000, i == 8, i == 3 || i == 15);
		while (words_sent < WORD_TARGET)
			send_message($urandom_range(99) < 60 ? 1 : $urandom_range(4, 2));
		msg_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// digest side: random stalls, a quiet stretch and one long hold-off
	initial begin
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (digest_valid && !digest_stall)
				taken++;
			if (!held && taken >= 24) begin
				held = 1'b1;
				digest_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				digest_stall <= !(taken >= 60 && taken < 110) && $urandom_range(99) < 14;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (msg_valid && !msg_stall) || (digest_valid && !digest_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
